>>> hdl/imab_pkg.sv
// Shared types, constants and lookup functions for the IMA ADPCM block decoder.
package imab_pkg;

   localparam int STEP_TABLE_SIZE     = 89;
   localparam int GROUP_BYTES         = 4;
   localparam int HEADER_BYTES        = 4;
   localparam int MAX_STEP_POS        = 88;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CODE_W      = 8;
   localparam int SAMPLE_W    = 16;
   localparam int BLOCK_W     = 16;
   localparam int VOL_W       = 7;
   localparam int POS_W       = 7;
   localparam int STEP_W      = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RESET = 16'd1024;
   localparam logic [VOL_W-1:0]   VOLUME_RESET      = 7'd100;
   localparam logic [VOL_W-1:0]   FULL_VOLUME       = 7'd100;

   // floor(m/100) as (m * DIV_MULT) >> DIV_SHIFT, exact for m below 2^22
   localparam int              DIV_SHIFT = 29;
   localparam int              MAG_W     = SAMPLE_W + VOL_W;
   localparam logic [22:0]     DIV_MULT  = 23'd5368710;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_BYTES = 2'd0,
      CSR_STEREO      = 2'd1,
      CSR_VOLUME      = 2'd2
   } imab_csr_index_type;

   typedef enum logic [1:0] {
      KIND_HDR_PRED = 2'd0,
      KIND_HDR_STEP = 2'd1,
      KIND_MONO     = 2'd2,
      KIND_STEREO   = 2'd3
   } imab_kind_type;

   // One decode job handed from the front to the back
   typedef struct packed {
      imab_kind_type     kind;
      logic              ch;
      logic [15:0]       data;
      logic              last;
   } imab_cmd_type;

   localparam logic [STEP_W-1:0] STEP_SIZES [STEP_TABLE_SIZE] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
      15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
      15'd27086, 15'd29794, 15'd32767
   };

   function automatic logic [STEP_W-1:0] step_size(input logic [POS_W-1:0] pos);
      if (pos > POS_W'(MAX_STEP_POS)) begin
         return STEP_SIZES[MAX_STEP_POS];
      end
      return STEP_SIZES[pos];
   endfunction

   function automatic logic signed [4:0] index_move(input logic [2:0] code);
      logic signed [4:0] mv;
      unique case (code)
         3'd4:    mv = 5'sd2;
         3'd5:    mv = 5'sd4;
         3'd6:    mv = 5'sd6;
         3'd7:    mv = 5'sd8;
         default: mv = -5'sd1;
      endcase
      return mv;
   endfunction

endpackage

>>> hdl/imab_if.sv
// Channel interfaces: compressed byte input, PCM result output, register writes.
interface imab_req_if;
   import imab_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] code_byte;
   logic              stream_end;
   modport source (output valid, code_byte, stream_end, input ready);
   modport sink   (input valid, code_byte, stream_end, output ready);
endinterface

interface imab_rsp_if;
   import imab_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] pcm_sample;
   logic                       run_last;
   logic                       stream_done;
   modport source (output valid, pcm_sample, run_last, stream_done, input ready);
   modport sink   (input valid, pcm_sample, run_last, stream_done, output ready);
endinterface

interface imab_csr_if;
   import imab_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/imab_front.sv
// Front end: tracks the block offset, takes headers apart, buffers left bytes, issues jobs.
module imab_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [imab_pkg::CODE_W-1:0]  code_byte,
   input  logic                         stream_end,
   input  logic [imab_pkg::BLOCK_W-1:0] block_bytes,
   input  logic                         stereo,
   output logic                         push_valid,
   input  logic                         push_ready,
   output imab_pkg::imab_cmd_type       push_cmd
);
   import imab_pkg::*;

   localparam int GRP_SHIFT  = $clog2(2 * GROUP_BYTES);
   localparam int LEFT_W     = $clog2(GROUP_BYTES);
   localparam int HDR_POS_W  = $clog2(HEADER_BYTES);
   localparam logic [HDR_POS_W-1:0] HDR_POS_LOW  = HDR_POS_W'(0);
   localparam logic [HDR_POS_W-1:0] HDR_POS_HIGH = HDR_POS_W'(1);
   localparam logic [HDR_POS_W-1:0] HDR_POS_STEP = HDR_POS_W'(2);
   localparam logic [BLOCK_W-1:0]   STEREO_HDR   = BLOCK_W'(2 * HEADER_BYTES);

   logic [BLOCK_W-1:0] offset_ff, offset_in;
   logic [CODE_W-1:0]  header_low_ff, header_low_in;
   logic [CODE_W-1:0]  left_ff [GROUP_BYTES];

   logic [BLOCK_W-1:0]   hdr_len, blk_len, data_off, data_len;
   logic                 accept, in_header, in_group, is_left;
   logic [HDR_POS_W-1:0] hdr_pos;
   logic                 hdr_ch;
   logic [LEFT_W-1:0]    left_idx;
   logic [BLOCK_W:0]     off_next;
   logic [CODE_W-1:0]    step_clamped;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hdr_len   = stereo ? STEREO_HDR : BLOCK_W'(HEADER_BYTES);
      blk_len   = (block_bytes < hdr_len) ? hdr_len : block_bytes;
      in_header = offset_ff < hdr_len;
      hdr_pos   = offset_ff[HDR_POS_W-1:0];
      hdr_ch    = offset_ff[HDR_POS_W];
      data_off  = offset_ff - STEREO_HDR;
      data_len  = blk_len - STEREO_HDR;
      in_group  = (data_off >> GRP_SHIFT) < (data_len >> GRP_SHIFT);
      is_left   = !data_off[GRP_SHIFT-1];
      left_idx  = data_off[LEFT_W-1:0];
      off_next  = {1'b0, offset_ff} + (BLOCK_W+1)'(1);
      step_clamped = (code_byte > CODE_W'(MAX_STEP_POS)) ? CODE_W'(MAX_STEP_POS)
                                                         : code_byte;
   end

   always_comb begin
      push_valid    = 1'b0;
      push_cmd.kind = KIND_MONO;
      push_cmd.ch   = hdr_ch;
      push_cmd.data = {8'd0, code_byte};
      push_cmd.last = stream_end;
      header_low_in = header_low_ff;
      if (in_header) begin
         if (hdr_pos == HDR_POS_LOW) begin
            header_low_in = accept ? code_byte : header_low_ff;
         end else if (hdr_pos == HDR_POS_HIGH) begin
            push_valid    = req_valid;
            push_cmd.kind = KIND_HDR_PRED;
            push_cmd.data = {code_byte, header_low_ff};
         end else if (hdr_pos == HDR_POS_STEP) begin
            push_valid    = req_valid;
            push_cmd.kind = KIND_HDR_STEP;
            push_cmd.data = {8'd0, step_clamped};
         end
      end else if (!stereo) begin
         push_valid = req_valid;
      end else if (in_group && !is_left) begin
         push_valid    = req_valid;
         push_cmd.kind = KIND_STEREO;
         push_cmd.data = {left_ff[left_idx], code_byte};
      end
   end

   // wrap at the end of the block or of the stream
   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         if (stream_end || off_next >= {1'b0, blk_len}) begin
            offset_in = '0;
         end else begin
            offset_in = off_next[BLOCK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         header_low_ff <= '0;
      end else begin
         offset_ff     <= offset_in;
         header_low_ff <= header_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !in_header && stereo && in_group && is_left) begin
         left_ff[left_idx] <= code_byte;
      end
   end

endmodule

>>> hdl/imab_queue.sv
// Small job queue between front and back.
module imab_queue #(
   parameter int DEPTH = imab_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  imab_pkg::imab_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output imab_pkg::imab_cmd_type pop_cmd
);
   import imab_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   imab_cmd_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> hdl/imab_back.sv
// Back end: nibble decoder with channel state, then volume scaling pipeline.
module imab_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [imab_pkg::VOL_W-1:0]          volume_percent,
   input  logic                                cmd_valid,
   output logic                                cmd_ready,
   input  imab_pkg::imab_cmd_type              cmd,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [imab_pkg::SAMPLE_W-1:0] pcm_sample,
   output logic                                run_last,
   output logic                                stream_done
);
   import imab_pkg::*;

   localparam int PROD_W = MAG_W + 23;
   localparam int D_W    = SAMPLE_W + 2;

   logic signed [SAMPLE_W-1:0] pred_ff [2];
   logic [POS_W-1:0]           pos_ff [2];
   logic [1:0]                 step_ff, step_in;

   // decode stage result
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff, s1_sample_in;
   logic                       s1_last_ff, s1_last_in, s1_done_ff, s1_done_in;
   // magnitude times volume
   logic                       s2_valid_ff, s2_last_ff, s2_done_ff, s2_neg_ff, s2_pass_ff;
   logic [MAG_W-1:0]           s2_mag_ff;
   logic signed [SAMPLE_W-1:0] s2_sample_ff;
   // reciprocal multiply
   logic                       s3_valid_ff, s3_last_ff, s3_done_ff, s3_neg_ff, s3_pass_ff;
   logic [PROD_W-1:0]          s3_prod_ff;
   logic signed [SAMPLE_W-1:0] s3_sample_ff;
   // output register
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_last_ff, out_done_ff;

   logic                       adv, final_step, ch, emit, upd_pred, upd_pos;
   logic [3:0]                 code;
   logic [POS_W-1:0]           pos, new_pos;
   logic [STEP_W-1:0]          step;
   logic [SAMPLE_W-1:0]        delta, s1_abs, quot;
   logic signed [D_W-1:0]      sum;
   logic signed [POS_W+1:0]    np;
   logic signed [SAMPLE_W-1:0] new_pred;

   // the whole pipe moves when the output register can take a word
   assign adv = !out_valid_ff || rsp_ready;

   always_comb begin
      unique case (cmd.kind)
         KIND_MONO: begin
            final_step = step_ff == 2'd1;
            ch         = 1'b0;
            code       = step_ff[0] ? cmd.data[7:4] : cmd.data[3:0];
         end
         KIND_STEREO: begin
            final_step = step_ff == 2'd3;
            ch         = step_ff[0];
            code       = step_ff[0] ? (step_ff[1] ? cmd.data[7:4] : cmd.data[3:0])
                                    : (step_ff[1] ? cmd.data[15:12] : cmd.data[11:8]);
         end
         default: begin
            final_step = 1'b1;
            ch         = cmd.ch;
            code       = cmd.data[3:0];
         end
      endcase
   end

   always_comb begin
      pos   = pos_ff[ch];
      step  = step_size(pos);
      delta = SAMPLE_W'(step >> 3);
      if (code[0]) delta = delta + SAMPLE_W'(step >> 2);
      if (code[1]) delta = delta + SAMPLE_W'(step >> 1);
      if (code[2]) delta = delta + SAMPLE_W'(step);
      if (code[3]) begin
         sum = D_W'(pred_ff[ch]) - $signed({2'b00, delta});
      end else begin
         sum = D_W'(pred_ff[ch]) + $signed({2'b00, delta});
      end
      if (sum > D_W'(32767)) begin
         new_pred = 16'sh7fff;
      end else if (sum < -D_W'(32768)) begin
         new_pred = 16'sh8000;
      end else begin
         new_pred = sum[SAMPLE_W-1:0];
      end
      np = $signed({2'b00, pos}) + (POS_W+2)'(index_move(code[2:0]));
      if (np < 0) begin
         new_pos = '0;
      end else if (np > (POS_W+2)'(MAX_STEP_POS)) begin
         new_pos = POS_W'(MAX_STEP_POS);
      end else begin
         new_pos = np[POS_W-1:0];
      end
   end

   always_comb begin
      cmd_ready    = adv && final_step;
      step_in      = step_ff;
      emit         = 1'b0;
      upd_pred     = 1'b0;
      upd_pos      = 1'b0;
      s1_sample_in = new_pred;
      if (cmd_valid && adv) begin
         step_in = final_step ? 2'd0 : step_ff + 2'd1;
         unique case (cmd.kind)
            KIND_HDR_PRED: begin
               emit         = 1'b1;
               upd_pred     = 1'b1;
               s1_sample_in = $signed(cmd.data);
            end
            KIND_HDR_STEP: begin
               upd_pos = 1'b1;
            end
            default: begin
               emit     = 1'b1;
               upd_pred = 1'b1;
               upd_pos  = 1'b1;
            end
         endcase
      end
      s1_valid_in = adv ? emit : s1_valid_ff;
      s1_last_in  = final_step;
      s1_done_in  = final_step && cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff[0] <= '0;
         pred_ff[1] <= '0;
         pos_ff[0]  <= '0;
         pos_ff[1]  <= '0;
         step_ff    <= '0;
      end else begin
         step_ff <= step_in;
         if (upd_pred) begin
            pred_ff[ch] <= s1_sample_in;
         end
         if (upd_pos) begin
            pos_ff[ch] <= (cmd.kind == KIND_HDR_STEP) ? cmd.data[POS_W-1:0] : new_pos;
         end
      end
   end

   assign s1_abs = s1_sample_ff[SAMPLE_W-1] ? SAMPLE_W'(-s1_sample_ff) : s1_sample_ff;
   assign quot   = s3_prod_ff[DIV_SHIFT +: SAMPLE_W];

   always_comb begin
      if (s3_pass_ff) begin
         out_sample_in = s3_sample_ff;
      end else if (s3_neg_ff) begin
         out_sample_in = $signed(SAMPLE_W'(-quot));
      end else begin
         out_sample_in = $signed(quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (adv) begin
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sample_ff  <= s1_sample_in;
         s1_last_ff    <= s1_last_in;
         s1_done_ff    <= s1_done_in;
         s2_mag_ff     <= MAG_W'(s1_abs) * MAG_W'(volume_percent);
         s2_neg_ff     <= s1_sample_ff[SAMPLE_W-1];
         s2_pass_ff    <= volume_percent >= FULL_VOLUME;
         s2_sample_ff  <= s1_sample_ff;
         s2_last_ff    <= s1_last_ff;
         s2_done_ff    <= s1_done_ff;
         s3_prod_ff    <= PROD_W'(s2_mag_ff) * PROD_W'(DIV_MULT);
         s3_neg_ff     <= s2_neg_ff;
         s3_pass_ff    <= s2_pass_ff;
         s3_sample_ff  <= s2_sample_ff;
         s3_last_ff    <= s2_last_ff;
         s3_done_ff    <= s2_done_ff;
         out_sample_ff <= out_sample_in;
         out_last_ff   <= s3_last_ff;
         out_done_ff   <= s3_done_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign pcm_sample  = out_sample_ff;
   assign run_last    = out_last_ff;
   assign stream_done = out_done_ff;

endmodule

>>> hdl/ima_adpcm_block_decoder.sv
// Top level of the block-structured IMA ADPCM decoder: config registers and the three parts.
//
// Takes the compressed stream one byte per word on req_bus and returns signed 16-bit PCM
// words on rsp_bus. Each block starts with a 4-byte header per channel (predictor low,
// predictor high, step index clamped to 88, spare); the header predictor comes out as a
// sample. Mono data bytes give two samples, low nibble first. Stereo data arrives as four
// left bytes, held in a small buffer, then four right bytes; each right byte gives
// L lo, R lo, L hi, R hi. Stereo bytes after the last full group of a block give nothing.
// run_last marks the last sample of each byte and stream_done the last sample of the byte
// flagged with stream_end. Below 100 percent the volume scales each sample, truncating
// towards zero. The front part takes one byte per cycle into a job queue while the queue
// has room; the back part decodes one nibble per cycle while the output register is not
// held. Header low and spare bytes, stereo left bytes and skipped tail bytes make no job.
// With the queue empty a byte's job passes the queue memory and the decode, magnitude,
// reciprocal and output registers to rsp_bus. While the output register holds an untaken
// sample, the whole back part holds; the queue takes bytes until full, then req_bus stalls.
// Write the registers on csr_bus only while the decoder is idle: index 0 block_bytes,
// 1 stereo, 2 volume_percent; other indexes are dropped.
module ima_adpcm_block_decoder #(
   parameter int QUEUE_DEPTH = imab_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   imab_req_if.sink   req_bus,
   imab_rsp_if.source rsp_bus,
   imab_csr_if.sink   csr_bus
);
   import imab_pkg::*;

   logic [BLOCK_W-1:0] block_bytes_ff, block_bytes_in;
   logic               stereo_ff, stereo_in;
   logic [VOL_W-1:0]   volume_ff, volume_in;
   logic               csr_write;

   logic               push_valid, push_ready, pop_valid, pop_ready;
   imab_cmd_type       push_cmd, pop_cmd;

   // register port never stalls
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      block_bytes_in = block_bytes_ff;
      stereo_in      = stereo_ff;
      volume_in      = volume_ff;
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_BLOCK_BYTES: block_bytes_in = csr_bus.data[BLOCK_W-1:0];
            CSR_STEREO:      stereo_in      = csr_bus.data[0];
            CSR_VOLUME:      volume_in      = csr_bus.data[VOL_W-1:0];
            default:         ; // unused index: drop the word
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= BLOCK_BYTES_RESET;
         stereo_ff      <= 1'b0;
         volume_ff      <= VOLUME_RESET;
      end else begin
         block_bytes_ff <= block_bytes_in;
         stereo_ff      <= stereo_in;
         volume_ff      <= volume_in;
      end
   end

   // front: offset tracking, header capture, left-byte buffer
   imab_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .code_byte   (req_bus.code_byte),
      .stream_end  (req_bus.stream_end),
      .block_bytes (block_bytes_ff),
      .stereo      (stereo_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   // decouple byte intake from nibble decoding
   imab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: predictor state, nibble decode, volume scaling, output register
   imab_back u_back (
      .clock          (clock),
      .reset          (reset),
      .volume_percent (volume_ff),
      .cmd_valid      (pop_valid),
      .cmd_ready      (pop_ready),
      .cmd            (pop_cmd),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .pcm_sample     (rsp_bus.pcm_sample),
      .run_last       (rsp_bus.run_last),
      .stream_done    (rsp_bus.stream_done)
   );

endmodule
